// ===== hw/rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes for the first-fit block allocator: request and
// response words, status codes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ffba_pkg;

   localparam logic       REQ_ALLOC   = 1'b0;
   localparam logic       REQ_FREE    = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOFIT    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;

   typedef struct packed {
      logic       req_type;
      logic [9:0] alloc_size;
      logic [9:0] free_addr;
   } req_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic [9:0] addr;
      logic [3:0] block_index;
   } rsp_word_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_SPLIT_NEW,
      S_WR_PICK,
      S_DONE
   } ctl_state_type;

   typedef struct packed {
      logic       load_req;
      logic       init_wr;
      logic       scan_rd;
      logic       idx_inc;
      logic       latch_pick;
      logic       shift_start;
      logic       shift_rd;
      logic       shift_wr;
      logic       split_wr;
      logic       pick_wr;
      logic       set_status;
      logic [1:0] status;
      logic       rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic size_zero;
      logic free_op;
      logic hit;
      logic split_ok;
      logic last;
      logic shift_done;
      logic rsp_ready;
   } dp_status_type;

endpackage

// ===== hw/rtl/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// Controller state machine: table init after reset, first-fit scan, entry
// shift for a split, entry updates and response handoff.
// ----------------------------------------------------------------------------
module ffba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ffba_pkg::dp_status_type dp_status,
   output ffba_pkg::ctl_cmd_type   cmd
);
   import ffba_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (!dp_status.free_op && dp_status.size_zero) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (dp_status.hit) begin
               if (!dp_status.free_op && dp_status.split_ok) begin
                  state_in = S_SHIFT_RD;
               end else begin
                  state_in = S_WR_PICK;
               end
            end else if (dp_status.last) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            if (dp_status.shift_done) begin
               state_in = S_SPLIT_NEW;
            end else begin
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            state_in = S_SHIFT_RD;
         end
         S_SPLIT_NEW: begin
            state_in = S_WR_PICK;
         end
         S_WR_PICK: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (dp_status.rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_INIT: begin
            cmd.init_wr = 1'b1;
         end
         S_IDLE: begin
            cmd.load_req = req_valid;
         end
         S_SCAN_RD: begin
            if (!dp_status.free_op && dp_status.size_zero) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NOFIT;
            end else begin
               cmd.scan_rd = 1'b1;
            end
         end
         S_SCAN_CHK: begin
            if (dp_status.hit) begin
               cmd.latch_pick  = 1'b1;
               cmd.shift_start = !dp_status.free_op && dp_status.split_ok;
            end else if (dp_status.last) begin
               cmd.set_status = 1'b1;
               cmd.status     = dp_status.free_op ? ST_NOTFOUND : ST_NOFIT;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_SHIFT_RD: begin
            cmd.shift_rd = !dp_status.shift_done;
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
         end
         S_SPLIT_NEW: begin
            cmd.split_wr = 1'b1;
         end
         S_WR_PICK: begin
            cmd.pick_wr    = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
         end
         S_DONE: begin
            cmd.rsp_load = dp_status.rsp_ready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/ffba_datapath.sv =====
// ----------------------------------------------------------------------------
// ffba_datapath
// Block table memory, scan and shift index, picked entry, split arithmetic
// and the response register.
// ----------------------------------------------------------------------------
module ffba_datapath #(
   parameter int POOL_BYTES   = 1024,
   parameter int HEADER_BYTES = 16,
   parameter int MAX_BLOCKS   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ffba_pkg::req_word_type  req_word,
   input  ffba_pkg::ctl_cmd_type   cmd,
   output ffba_pkg::dp_status_type dp_status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ffba_pkg::rsp_word_type  rsp_word
);
   import ffba_pkg::*;

   localparam int OFF_W = $clog2(POOL_BYTES + 1);
   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int ENT_W = 2 * OFF_W + 1;
   localparam int CW    = ((OFF_W > 10) ? OFF_W : 10) + 1;

   localparam logic [OFF_W-1:0] INIT_START = OFF_W'(HEADER_BYTES);
   localparam logic [OFF_W-1:0] INIT_SIZE  = OFF_W'(POOL_BYTES - HEADER_BYTES);
   localparam logic [CW-1:0]    HDR_C      = CW'(HEADER_BYTES);

   logic [ENT_W-1:0] mem [MAX_BLOCKS];

   req_word_type     op_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic [IDX_W-1:0] pick_ff;
   logic [ENT_W-1:0] ent_ff;
   logic             split_ff;
   logic [CNT_W-1:0] count_ff;
   logic [ENT_W-1:0] rd_ff;
   logic [1:0]       status_ff;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_word_ff;

   logic             we;
   logic [IDX_W-1:0] waddr;
   logic [ENT_W-1:0] wdata;
   logic [IDX_W-1:0] raddr;
   logic             re;

   logic [OFF_W-1:0] rd_start;
   logic [OFF_W-1:0] rd_size;
   logic             rd_free;
   logic [OFF_W-1:0] ent_start;
   logic [OFF_W-1:0] ent_size;
   logic [CW-1:0]    req_c;
   logic [CW-1:0]    rd_size_c;
   logic [CW-1:0]    rd_start_c;
   logic [CW-1:0]    where_c;
   logic [CW-1:0]    rem_c;
   logic [CW-1:0]    ent_rem_c;
   logic [CW-1:0]    new_start_c;
   logic [CW-1:0]    new_size_c;
   logic             rsp_ready;
   logic [CW-1:0]    ent_start_c;
   logic [IDX_W+3:0] pick_ext;

   assign rd_start    = rd_ff[2*OFF_W:OFF_W+1];
   assign rd_size     = rd_ff[OFF_W:1];
   assign rd_free     = rd_ff[0];
   assign ent_start   = ent_ff[2*OFF_W:OFF_W+1];
   assign ent_size    = ent_ff[OFF_W:1];
   assign req_c       = CW'(op_ff.alloc_size);
   assign where_c     = CW'(op_ff.free_addr);
   assign rd_size_c   = CW'(rd_size);
   assign rd_start_c  = CW'(rd_start);
   assign ent_start_c = CW'(ent_start);
   assign rem_c       = rd_size_c - req_c;
   assign ent_rem_c   = CW'(ent_size) - req_c;
   assign new_start_c = ent_start_c + req_c + HDR_C;
   assign new_size_c  = ent_rem_c - HDR_C;
   assign pick_ext    = {4'b0000, pick_ff};

   // status to controller
   assign rsp_ready            = !rsp_valid_ff || !rsp_stall;
   assign dp_status.size_zero  = (op_ff.alloc_size == 10'd0);
   assign dp_status.free_op    = (op_ff.req_type == REQ_FREE);
   assign dp_status.hit        = (op_ff.req_type == REQ_FREE) ?
                                 (rd_start_c == where_c) :
                                 (rd_free && (rd_size_c >= req_c));
   assign dp_status.split_ok   = (rem_c > HDR_C) && (count_ff != CNT_W'(MAX_BLOCKS));
   assign dp_status.last       = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign dp_status.shift_done = (CNT_W'(idx_ff) == (CNT_W'(pick_ff) + CNT_W'(1)));
   assign dp_status.rsp_ready  = rsp_ready;

   // table write and read port selection
   always_comb begin
      we    = cmd.init_wr || cmd.shift_wr || cmd.split_wr || cmd.pick_wr;
      waddr = pick_ff;
      wdata = {ent_start, ent_size, 1'b0};
      if (cmd.init_wr) begin
         waddr = '0;
         wdata = {INIT_START, INIT_SIZE, 1'b1};
      end else if (cmd.shift_wr) begin
         waddr = idx_ff;
         wdata = rd_ff;
      end else if (cmd.split_wr) begin
         waddr = pick_ff + IDX_W'(1);
         wdata = {new_start_c[OFF_W-1:0], new_size_c[OFF_W-1:0], 1'b1};
      end else if (split_ff) begin
         wdata = {ent_start, req_c[OFF_W-1:0], 1'b0};
      end else begin
         wdata = {ent_start, ent_size, (op_ff.req_type == REQ_FREE)};
      end
      re    = cmd.scan_rd || cmd.shift_rd;
      raddr = cmd.shift_rd ? (idx_ff - IDX_W'(1)) : idx_ff;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_ff <= mem[raddr];
      end
   end

   // scan and shift index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.load_req) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end else if (cmd.shift_start) begin
         idx_in = count_ff[IDX_W-1:0];
      end else if (cmd.shift_wr) begin
         idx_in = idx_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_req) begin
         op_ff <= req_word;
      end
      if (cmd.latch_pick) begin
         pick_ff  <= idx_ff;
         ent_ff   <= rd_ff;
         split_ff <= dp_status.split_ok && (op_ff.req_type == REQ_ALLOC);
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(1);
      end else if (cmd.split_wr) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_word_ff.status <= status_ff;
         if (status_ff == ST_OK) begin
            rsp_word_ff.addr        <= ent_start_c[9:0];
            rsp_word_ff.block_index <= pick_ext[3:0];
         end else begin
            rsp_word_ff.addr        <= '0;
            rsp_word_ff.block_index <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== hw/rtl/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a byte pool, kept as an address-ordered table of
// blocks with start, size and free mark. Allocate splits a larger block, when
// the remainder exceeds a header and the table has room, by inserting a new
// free block behind it; free marks the block by its start.
// One request is handled at a time. After reset the table is initialized by
// one write of a single free block over the pool. A request is taken, then
// the table memory is scanned entry by entry, one read and one compare per
// entry. A free or a whole-block allocate then writes the picked entry; a
// split first moves each entry behind the picked one up to open a slot, with
// one read and one write per entry, then writes the new block and the picked
// entry. A request that finds nothing, or a zero-size allocate, ends with a
// reject status. A result is loaded only once the output register is free or
// being emptied. A finished result waits in an output register while the
// next request is accepted.
module first_fit_block_allocator #(
   parameter int POOL_BYTES   = 1024,
   parameter int HEADER_BYTES = 16,
   parameter int MAX_BLOCKS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ffba_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ffba_pkg::rsp_word_type rsp_word
);
   import ffba_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type dp_status;

   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   ffba_datapath #(
      .POOL_BYTES   (POOL_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_BLOCKS   (MAX_BLOCKS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== dv/first_fit_block_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb
// Self-checking bench for the first-fit block allocator. A queue-fed driver
// sends allocate and free words with random gaps, and a monitor takes results
// under random stall. Each result is checked field by field against a shadow
// block table kept in the bench. A short directed opening covers rejects,
// exact and whole-block fits, splits and the top offset. Random traffic then
// mostly frees live blocks and allocates small sizes, with some noise.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb;
   import ffba_pkg::*;

   localparam int POOL_BYTES   = 1024;
   localparam int HEADER_BYTES = 16;
   localparam int MAX_BLOCKS   = 16;
   localparam int RANDOM_WORDS = 800;
   localparam int DRAIN_CYCLES = 80;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   int           blk_start [MAX_BLOCKS];
   int           blk_size  [MAX_BLOCKS];
   bit           blk_free  [MAX_BLOCKS];
   int           blk_count;

   req_word_type req_pending_q[$];
   rsp_word_type rsp_expected_q[$];
   int           words_in_flight = 0;
   int           mismatches = 0;
   int           send_gap = 0;
   int           stall_left = 0;
   int           stall_draw;
   bit           tx_burst = 1'b0;
   bit           rx_burst = 1'b0;
   rsp_word_type want;

   first_fit_block_allocator #(
      .POOL_BYTES   (POOL_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_BLOCKS   (MAX_BLOCKS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic rsp_word_type alloc_or_release(req_word_type w);
      rsp_word_type r;
      int           pick;
      int           rem;
      r = '0;
      pick = -1;
      if (w.req_type == REQ_ALLOC) begin
         r.status = ST_NOFIT;
         if (w.alloc_size != 0) begin
            for (int i = 0; i < blk_count; i++) begin
               if (pick < 0 && blk_free[i] && blk_size[i] >= int'(w.alloc_size)) begin
                  pick = i;
               end
            end
         end
         if (pick >= 0) begin
            blk_free[pick] = 1'b0;
            rem = blk_size[pick] - int'(w.alloc_size);
            if (rem > HEADER_BYTES && blk_count < MAX_BLOCKS) begin
               for (int j = blk_count; j > pick + 1; j--) begin
                  blk_start[j] = blk_start[j-1];
                  blk_size[j]  = blk_size[j-1];
                  blk_free[j]  = blk_free[j-1];
               end
               blk_start[pick+1] = blk_start[pick] + int'(w.alloc_size) + HEADER_BYTES;
               blk_size[pick+1]  = rem - HEADER_BYTES;
               blk_free[pick+1]  = 1'b1;
               blk_size[pick]    = int'(w.alloc_size);
               blk_count++;
            end
            r.status      = ST_OK;
            r.addr        = 10'(blk_start[pick]);
            r.block_index = 4'(pick);
         end
      end else begin
         r.status = ST_NOTFOUND;
         for (int i = 0; i < blk_count; i++) begin
            if (pick < 0 && blk_start[i] == int'(w.free_addr)) begin
               pick = i;
            end
         end
         if (pick >= 0) begin
            blk_free[pick] = 1'b1;
            r.status       = ST_OK;
            r.addr         = w.free_addr;
            r.block_index  = 4'(pick);
         end
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            blk_start[i] = 0;
            blk_size[i]  = 0;
            blk_free[i]  = 1'b0;
         end
         blk_start[0] = HEADER_BYTES;
         blk_size[0]  = POOL_BYTES - HEADER_BYTES;
         blk_free[0]  = 1'b1;
         blk_count    = 1;
      end else begin
         if (req_valid && !req_stall) begin
            rsp_expected_q.push_back(alloc_or_release(req_word));
            words_in_flight--;
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (req_pending_q.size() != 0) begin
               req_word  <= req_pending_q.pop_front();
               req_valid <= 1'b1;
               send_gap  <= tx_burst ? 0 : $urandom_range(0, 15);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (rsp_expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result word: status %0d addr %0d index %0d",
                        rsp_word.status, rsp_word.addr, rsp_word.block_index);
            end
         end else begin
            want = rsp_expected_q.pop_front();
            if (rsp_word.status != want.status || rsp_word.addr != want.addr ||
                rsp_word.block_index != want.block_index) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result mismatch: expected status %0d addr %0d index %0d, got status %0d addr %0d index %0d",
                           want.status, want.addr, want.block_index,
                           rsp_word.status, rsp_word.addr, rsp_word.block_index);
               end
            end
         end
         stall_draw = rx_burst ? 0 : $urandom_range(0, 15);
         stall_left <= stall_draw;
         rsp_stall  <= (stall_draw != 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end
   end

   task automatic queue_word(logic kind, int size, int where);
      req_word_type w;
      w.req_type   = kind;
      w.alloc_size = 10'(size);
      w.free_addr  = 10'(where);
      words_in_flight++;
      req_pending_q.push_back(w);
   endtask

   initial begin
      int pick_kind;
      int size;
      int where;
      @(negedge reset);
      // rejects on a fresh pool
      queue_word(REQ_ALLOC, 0, 1023);
      queue_word(REQ_ALLOC, 1023, 0);
      queue_word(REQ_ALLOC, 1009, 0);
      queue_word(REQ_FREE, 1023, 0);
      queue_word(REQ_FREE, 0, 1023);
      // remainder too small for a header, whole block handed out
      queue_word(REQ_ALLOC, 1000, 0);
      queue_word(REQ_ALLOC, 1, 0);
      queue_word(REQ_FREE, 0, HEADER_BYTES);
      queue_word(REQ_FREE, 0, HEADER_BYTES);
      // exact fit
      queue_word(REQ_ALLOC, 1008, 0);
      queue_word(REQ_FREE, 0, HEADER_BYTES);
      queue_word(REQ_ALLOC, 992, 0);
      queue_word(REQ_FREE, 0, HEADER_BYTES);
      // split leaving a one-byte block at the top offset
      queue_word(REQ_ALLOC, 991, 0);
      queue_word(REQ_ALLOC, 1, 0);
      queue_word(REQ_FREE, 0, 1023);
      queue_word(REQ_FREE, 0, HEADER_BYTES);
      queue_word(REQ_ALLOC, 1, 682);
      queue_word(REQ_ALLOC, 512, 341);
      queue_word(REQ_FREE, 682, 17);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 100 == 0) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
         end
         if (n == 250 || n == 550) begin
            while (words_in_flight != 0 || rsp_expected_q.size() != 0) @(posedge clock);
         end
         while (req_pending_q.size() >= 4) @(posedge clock);
         pick_kind = $urandom_range(0, 99);
         size      = $urandom_range(0, 1023);
         where     = $urandom_range(0, 1023);
         if (pick_kind < 50) begin
            case ($urandom_range(0, 9))
               0:       size = 0;
               1:       size = $urandom_range(0, 1023);
               2, 3:    size = $urandom_range(1, 400);
               default: size = $urandom_range(1, 64);
            endcase
            queue_word(REQ_ALLOC, size, where);
         end else if (pick_kind < 85) begin
            // free a live table entry, so the table must be current
            while (words_in_flight != 0) @(posedge clock);
            where = blk_start[$urandom_range(0, blk_count - 1)];
            queue_word(REQ_FREE, size, where);
         end else begin
            queue_word(REQ_FREE, size, where);
         end
      end

      while (words_in_flight != 0 || rsp_expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("first_fit_block_allocator regression: pass");
      end else begin
         $display("first_fit_block_allocator regression: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("first_fit_block_allocator regression: fail");
      $finish;
   end

endmodule

// ===== first_fit_block_allocator.f =====
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_ctrl.sv
hw/rtl/ffba_datapath.sv
hw/rtl/first_fit_block_allocator.sv
dv/first_fit_block_allocator_tb.sv
